// ===== rtl/tms_pkg.sv =====
`timescale 1ns / 1ps

package tms_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int MAT_ELEMS       = 16;
	// Accumulator wide enough for four 64-bit products after the fraction shift.
	localparam int ACC_W           = 66;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_POP   = 2'd1,
		KIND_XFORM = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_WZERO = 2'd3
	} status_t;

	typedef struct packed {
		logic               start;
		logic signed [31:0] num;
		logic signed [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quo;
	} div_rsp_t;

	// Clamp a wide signed sum to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-32:0] hi;
		hi = v[ACC_W-1:31];
		if (hi == '0 || hi == '1) begin
			return v[31:0];
		end else if (v[ACC_W-1]) begin
			return 32'sh80000000;
		end else begin
			return 32'sh7fffffff;
		end
	endfunction

endpackage

// ===== rtl/tms_if.sv =====
`timescale 1ns / 1ps

interface tms_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [1:0]         row;
	logic [1:0]         col;
	logic signed [31:0] elem_value;
	logic               push_now;
	logic signed [31:0] vert_x;
	logic signed [31:0] vert_y;
	logic signed [31:0] vert_z;

	modport source (output valid, kind, row, col, elem_value, push_now, vert_x, vert_y,
		vert_z, input ready);
	modport sink (input valid, kind, row, col, elem_value, push_now, vert_x, vert_y,
		vert_z, output ready);
endinterface

interface tms_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic signed [31:0] read_value;
	logic [4:0]         level;

	modport source (output valid, status, out_x, out_y, out_z, read_value, level,
		input ready);
	modport sink (input valid, status, out_x, out_y, out_z, read_value, level,
		output ready);
endinterface

// ===== rtl/tms_div.sv =====
`timescale 1ns / 1ps

module tms_div
	import tms_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int NW = 32 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   rem_q;
	logic [NW-1:0] dvd_q;
	logic [31:0]   dmag_q;
	logic          neg_q;

	logic [32:0] rem_sh;
	logic [32:0] diff;
	logic        ge;
	logic [31:0] nmag;
	logic [31:0] dmag;

	assign nmag   = req.num[31] ? 32'(-req.num) : 32'(req.num);
	assign dmag   = req.den[31] ? 32'(-req.den) : 32'(req.den);
	assign rem_sh = {rem_q, dvd_q[NW-1]};
	assign diff   = rem_sh - {1'b0, dmag_q};
	assign ge     = (rem_sh >= {1'b0, dmag_q});

	// Restoring division, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q  <= '0;
			dvd_q  <= {nmag, FRAC_BITS'(0)};
			dmag_q <= dmag;
			neg_q  <= req.num[31] ^ req.den[31];
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : rem_sh[31:0];
			dvd_q <= {dvd_q[NW-2:0], ge};
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (neg_q) begin
			if (dvd_q[NW-1:32] == '0 && (!dvd_q[31] || dvd_q[30:0] == '0)) begin
				rsp.quo = 32'(-dvd_q[31:0]);
			end else begin
				rsp.quo = 32'sh80000000;
			end
		end else begin
			if (dvd_q[NW-1:31] == '0) begin
				rsp.quo = dvd_q[31:0];
			end else begin
				rsp.quo = 32'sh7fffffff;
			end
		end
	end

endmodule

// ===== rtl/transform_matrix_stack_top.sv =====
`timescale 1ns / 1ps

// Channel  Modport  Beat carries
// in_ch    sink     kind, row, col, elem_value, push_now, vert_x, vert_y, vert_z
// out_ch   source   status, out_x, out_y, out_z, read_value, level
//
// A push onto an empty stack copies the staging matrix; a push with a matrix
// product takes 64 multiply-accumulate steps on the one shared multiplier plus
// a 3-stage pipeline drain. A transform runs its multiply-accumulate steps,
// checks w and, if w is not zero, makes three divides in the serial divider.
// Reset clears the stack count, the staging matrix and all control state; the
// matrix memory needs no clearing pass. The block takes one beat at a time and
// holds a finished result in an output register while it accepts the next beat.

module transform_matrix_stack_top
	import tms_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tms_in_if.sink    in_ch,
	tms_out_if.source out_ch
);

	localparam int LW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int AW    = LW + 4;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int MEM_D = STACK_DEPTH * MAT_ELEMS;
	localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_COPY,
		S_MAC,
		S_RDW,
		S_WCHK,
		S_DIV,
		S_FIN
	} state_t;

	state_t state_q;

	// Stack memory: one write and one registered read per cycle.
	logic signed [31:0] mem [MEM_D];
	logic signed [31:0] rd_q;
	logic [AW-1:0]      rd_addr;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic signed [31:0] mem_wdata;

	logic [CNT_W-1:0]   cnt_q;
	logic signed [31:0] stg_q [MAT_ELEMS];
	logic signed [31:0] vx_q, vy_q, vz_q;
	logic               push_mode_q;
	logic [5:0]         iss_q;
	logic               iss_v_q;
	logic [1:0]         dix_q;
	logic signed [31:0] r_q [4];

	logic [LW-1:0] top_lvl;
	logic [LW-1:0] dst_lvl;
	logic          iss_last;

	// Multiply-accumulate pipeline.
	logic               v_s1, last_s1;
	logic [1:0]         k_s1;
	logic [3:0]         tag_s1;
	logic signed [31:0] b_s1;
	logic               v_s2, last_s2;
	logic [1:0]         k_s2;
	logic [3:0]         tag_s2;
	logic signed [63:0] prod_s2;
	logic               v_s3, last_s3;
	logic [3:0]         tag_s3;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [63:0] prod_sh;
	logic signed [31:0] acc_sat;

	logic [1:0]         i_iss, j_iss, k_iss;
	logic [3:0]         tag_iss;
	logic signed [31:0] b_iss;
	logic [3:0]         stg_raddr;

	// Result held until the output register is free.
	status_t            res_status_q;
	logic signed [31:0] res_x_q, res_y_q, res_z_q, res_rv_q;

	logic               out_v_q;
	logic [1:0]         out_status_q;
	logic signed [31:0] out_x_q, out_y_q, out_z_q, out_rv_q;
	logic [4:0]         out_level_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     div_start_q;

	logic in_acc;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign top_lvl     = LW'(cnt_q - 1'b1);
	assign dst_lvl     = LW'(cnt_q);

	// Step decode: a push walks i, j, k over 64 steps; a transform walks i, k.
	assign k_iss    = iss_q[1:0];
	assign j_iss    = iss_q[3:2];
	assign i_iss    = push_mode_q ? iss_q[5:4] : iss_q[3:2];
	assign tag_iss  = push_mode_q ? {i_iss, j_iss} : {2'b00, i_iss};
	assign iss_last = push_mode_q ? (iss_q == 6'd63) : (iss_q == 6'd15);
	assign stg_raddr = (state_q == S_COPY) ? iss_q[3:0] : {k_iss, j_iss};

	always_comb begin
		if (push_mode_q) begin
			b_iss = stg_q[stg_raddr];
		end else begin
			case (k_iss)
				2'd0:    b_iss = vx_q;
				2'd1:    b_iss = vy_q;
				2'd2:    b_iss = vz_q;
				default: b_iss = FX_ONE;
			endcase
		end
	end

	always_comb begin
		if (state_q == S_MAC) begin
			rd_addr = {top_lvl, i_iss, k_iss};
		end else begin
			rd_addr = {top_lvl, in_ch.row, in_ch.col};
		end
	end

	assign prod_sh = prod_s2 >>> FRAC_BITS;
	assign acc_sat = sat32(acc_q);

	always_comb begin
		if (state_q == S_COPY) begin
			mem_we    = 1'b1;
			mem_waddr = {dst_lvl, iss_q[3:0]};
			mem_wdata = stg_q[stg_raddr];
		end else begin
			mem_we    = (state_q == S_MAC) && push_mode_q && v_s3;
			mem_waddr = {dst_lvl, tag_s3};
			mem_wdata = acc_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[rd_addr];
	end

	// Datapath pipeline; valid bits are cleared by reset in the control block.
	always_ff @(posedge clk) begin
		k_s1    <= k_iss;
		tag_s1  <= tag_iss;
		last_s1 <= iss_last;
		b_s1    <= b_iss;
		prod_s2 <= rd_q * b_s1;
		k_s2    <= k_s1;
		tag_s2  <= tag_s1;
		last_s2 <= last_s1;
		if (v_s2) begin
			acc_q <= ((k_s2 == 2'd0) ? ACC_W'(0) : acc_q)
				+ {{(ACC_W-64){prod_sh[63]}}, prod_sh};
		end
		tag_s3  <= tag_s2;
		last_s3 <= last_s2;
	end

	assign div_req.start = div_start_q;
	assign div_req.num   = r_q[dix_q];
	assign div_req.den   = r_q[3];

	tms_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			for (int e = 0; e < MAT_ELEMS; e++) begin
				stg_q[e] <= '0;
			end
			push_mode_q <= 1'b0;
			iss_q       <= '0;
			iss_v_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			dix_q       <= '0;
			div_start_q <= 1'b0;
			out_v_q     <= 1'b0;
			res_status_q <= ST_OK;
		end else begin
			v_s1        <= (state_q == S_MAC) && iss_v_q;
			v_s2        <= v_s1;
			v_s3        <= v_s2 && (k_s2 == 2'd3);
			div_start_q <= 1'b0;
			if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						res_status_q <= ST_OK;
						res_x_q      <= '0;
						res_y_q      <= '0;
						res_z_q      <= '0;
						res_rv_q     <= '0;
						vx_q         <= in_ch.vert_x;
						vy_q         <= in_ch.vert_y;
						vz_q         <= in_ch.vert_z;
						iss_q        <= '0;
						state_q      <= S_FIN;
						unique case (kind_t'(in_ch.kind))
							KIND_LOAD: begin
								stg_q[{in_ch.row, in_ch.col}] <= in_ch.elem_value;
								if (in_ch.push_now) begin
									if (cnt_q >= CNT_W'(STACK_DEPTH)) begin
										res_status_q <= ST_FULL;
									end else if (cnt_q == '0) begin
										state_q <= S_COPY;
									end else begin
										push_mode_q <= 1'b1;
										iss_v_q     <= 1'b1;
										state_q     <= S_MAC;
									end
								end
							end
							KIND_POP: begin
								if (cnt_q == '0) begin
									res_status_q <= ST_EMPTY;
								end else begin
									cnt_q <= cnt_q - 1'b1;
								end
							end
							KIND_XFORM: begin
								if (cnt_q == '0) begin
									res_status_q <= ST_EMPTY;
								end else begin
									push_mode_q <= 1'b0;
									iss_v_q     <= 1'b1;
									state_q     <= S_MAC;
								end
							end
							KIND_READ: begin
								if (cnt_q == '0) begin
									res_status_q <= ST_EMPTY;
								end else begin
									state_q <= S_RDW;
								end
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_COPY: begin
					iss_q <= iss_q + 1'b1;
					if (iss_q[3:0] == 4'd15) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_FIN;
					end
				end
				S_MAC: begin
					if (iss_v_q) begin
						iss_q <= iss_q + 1'b1;
						if (iss_last) begin
							iss_v_q <= 1'b0;
						end
					end
					if (v_s3) begin
						if (!push_mode_q) begin
							r_q[tag_s3[1:0]] <= acc_sat;
						end
						if (last_s3) begin
							if (push_mode_q) begin
								cnt_q   <= cnt_q + 1'b1;
								state_q <= S_FIN;
							end else begin
								state_q <= S_WCHK;
							end
						end
					end
				end
				S_RDW: begin
					res_rv_q <= rd_q;
					state_q  <= S_FIN;
				end
				S_WCHK: begin
					if (r_q[3] == '0) begin
						res_status_q <= ST_WZERO;
						state_q      <= S_FIN;
					end else begin
						dix_q       <= '0;
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						case (dix_q)
							2'd0:    res_x_q <= div_rsp.quo;
							2'd1:    res_y_q <= div_rsp.quo;
							default: res_z_q <= div_rsp.quo;
						endcase
						if (dix_q == 2'd2) begin
							state_q <= S_FIN;
						end else begin
							dix_q       <= dix_q + 1'b1;
							div_start_q <= 1'b1;
						end
					end
				end
				S_FIN: begin
					if (!out_v_q || out_ch.ready) begin
						out_v_q      <= 1'b1;
						out_status_q <= res_status_q;
						out_x_q      <= res_x_q;
						out_y_q      <= res_y_q;
						out_z_q      <= res_z_q;
						out_rv_q     <= res_rv_q;
						out_level_q  <= 5'(cnt_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid      = out_v_q;
	assign out_ch.status     = out_status_q;
	assign out_ch.out_x      = out_x_q;
	assign out_ch.out_y      = out_y_q;
	assign out_ch.out_z      = out_z_q;
	assign out_ch.read_value = out_rv_q;
	assign out_ch.level      = out_level_q;

	// The stack never holds more matrices than it has room for.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// A pop on a non-empty stack lowers the count by one.
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_ch.kind == KIND_POP && cnt_q != '0)
		|=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("pop did not lower the count");

	// The stack memory is written only while a push is in progress.
	a_we: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_COPY || (state_q == S_MAC && push_mode_q)))
		else $error("stack write outside a push");

	// A divide starts only during the divide phase of a transform.
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start_q |-> (state_q == S_DIV && r_q[3] != '0))
		else $error("divide started out of sequence");

endmodule

// ===== tb/sv/tms_checker.sv =====
`timescale 1ns / 1ps

// Follows both channels, keeps its own copy of the matrix stack and checks
// every result beat, in order, against the predicted one.
module tms_checker
	import tms_pkg::*;
#(
	parameter int DEPTH = STACK_DEPTH_DEF,
	parameter int FRAC  = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tms_in_if    in_ch,
	tms_out_if   out_ch,
	output int   errors,
	output int   pending
);

	typedef struct {
		status_t            status;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] rd;
		logic [4:0]         level;
	} result_t;

	result_t            result_q[$];
	logic signed [31:0] mats[DEPTH][MAT_ELEMS];
	logic signed [31:0] staging[MAT_ELEMS];
	int                 level;

	assign pending = result_q.size();

	function automatic longint fx_mul(logic signed [31:0] a, logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return p >>> FRAC;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	// Apply one input beat to the shadow stack and return the result it yields.
	function automatic result_t apply_beat(kind_t kind, int idx, logic signed [31:0] val,
			logic push, logic signed [31:0] vx, logic signed [31:0] vy,
			logic signed [31:0] vz);
		result_t            r;
		longint             acc;
		logic signed [31:0] pt[4];
		logic signed [31:0] tv[4];
		r = '{ST_OK, 0, 0, 0, 0, 0};
		case (kind)
			KIND_LOAD: begin
				staging[idx] = val;
				if (push) begin
					if (level >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						for (int i = 0; i < 4; i++) begin
							for (int j = 0; j < 4; j++) begin
								if (level == 0) begin
									mats[0][i*4+j] = staging[i*4+j];
								end else begin
									acc = 0;
									for (int k = 0; k < 4; k++) begin
										acc += fx_mul(mats[level-1][i*4+k], staging[k*4+j]);
									end
									mats[level][i*4+j] = clamp32(acc);
								end
							end
						end
						level++;
					end
				end
			end
			KIND_POP: begin
				if (level == 0) begin
					r.status = ST_EMPTY;
				end else begin
					level--;
				end
			end
			default: begin
				if (level == 0) begin
					r.status = ST_EMPTY;
				end else if (kind == KIND_READ) begin
					r.rd = mats[level-1][idx];
				end else begin
					pt = '{vx, vy, vz, 32'sd1 <<< FRAC};
					for (int i = 0; i < 4; i++) begin
						acc = 0;
						for (int k = 0; k < 4; k++) begin
							acc += fx_mul(mats[level-1][i*4+k], pt[k]);
						end
						tv[i] = clamp32(acc);
					end
					if (tv[3] == 0) begin
						r.status = ST_WZERO;
					end else begin
						// Integer division truncates toward zero, as the block does.
						r.x = clamp32((longint'(tv[0]) <<< FRAC) / longint'(tv[3]));
						r.y = clamp32((longint'(tv[1]) <<< FRAC) / longint'(tv[3]));
						r.z = clamp32((longint'(tv[2]) <<< FRAC) / longint'(tv[3]));
					end
				end
			end
		endcase
		r.level = level[4:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t w;
		if (!arst_n) begin
			level = 0;
			errors = 0;
			result_q.delete();
			foreach (staging[i]) staging[i] = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				result_q.push_back(apply_beat(kind_t'(in_ch.kind), in_ch.row * 4 + in_ch.col,
					in_ch.elem_value, in_ch.push_now, in_ch.vert_x, in_ch.vert_y,
					in_ch.vert_z));
			end
			if (out_ch.valid && out_ch.ready) begin
				if (result_q.size() == 0) begin
					report("unexpected result beat", 0, 0);
				end else begin
					w = result_q.pop_front();
					if (out_ch.status !== w.status) report("status", out_ch.status, w.status);
					if (out_ch.out_x !== w.x) report("out_x", out_ch.out_x, w.x);
					if (out_ch.out_y !== w.y) report("out_y", out_ch.out_y, w.y);
					if (out_ch.out_z !== w.z) report("out_z", out_ch.out_z, w.z);
					if (out_ch.read_value !== w.rd) report("read_value", out_ch.read_value, w.rd);
					if (out_ch.level !== w.level) report("level", out_ch.level, w.level);
				end
			end
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

// Top of the bench. It makes the clock and reset, drives input beats with
// random gaps, stalls the result channel at random and gives the verdict. All
// prediction and comparison live in the checker beside the block.
module tb;
	import tms_pkg::*;

	localparam int ITEMS = 1850;

	logic clk;
	logic arst_n;
	logic calm;
	int   errors;
	int   pending;
	int   sent;

	tms_in_if  in_ch();
	tms_out_if out_ch();

	transform_matrix_stack_top u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	tms_checker u_checker (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.errors (errors),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Drive one beat from a falling edge and hold it until it is taken. The
	// valid line is left high, so a beat sent right after keeps it high.
	task automatic send(kind_t kind, logic [1:0] row, logic [1:0] col, logic signed [31:0] val,
			logic push, logic signed [31:0] vx, logic signed [31:0] vy,
			logic signed [31:0] vz);
		in_ch.valid      = 1'b1;
		in_ch.kind       = kind;
		in_ch.row        = row;
		in_ch.col        = col;
		in_ch.elem_value = val;
		in_ch.push_now   = push;
		in_ch.vert_x     = vx;
		in_ch.vert_y     = vy;
		in_ch.vert_z     = vz;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		sent++;
		// A gap between beats, in bursts, except near the end.
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
	endtask

	// Value of one matrix element. Most matrices are close to affine so that
	// the transforms give w away from zero; others are wild or have a zero w row.
	function automatic logic signed [31:0] elem(int r, int c, int style);
		if (style == 1) return $urandom;
		if (r == 3) return (c == 3 && style == 0) ? 32'sd65536 : 32'sd0;
		if (c == 3) return $signed($urandom_range(0, 2097152)) - 1048576;
		if (r == c) return 32'sd65536 + $signed($urandom_range(0, 32768)) - 16384;
		return $signed($urandom_range(0, 32768)) - 16384;
	endfunction

	function automatic logic signed [31:0] coord();
		if ($urandom_range(0, 4) == 0) return $urandom;
		return $signed($urandom_range(0, 16777216)) - 8388608;
	endfunction

	task automatic push_matrix();
		int style;
		style = $urandom_range(0, 9) < 7 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
		for (int i = 0; i < 16; i++) begin
			send(KIND_LOAD, i / 4, i % 4, elem(i / 4, i % 4, style), i == 15,
				$urandom, $urandom, $urandom);
		end
	endtask

	// Result side: ready drops in random bursts until the last part of the run.
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_ch.ready = 1'b0;
				repeat ($urandom_range(1, 18) - 1) @(negedge clk);
			end else begin
				out_ch.ready = 1'b1;
				repeat ($urandom_range(0, 30)) @(negedge clk);
			end
		end
	end

	initial begin
		int pick;
		int waited;
		calm = 1'b0;
		sent = 0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_LOAD;
		in_ch.row = '0;
		in_ch.col = '0;
		in_ch.elem_value = '0;
		in_ch.push_now = 1'b0;
		in_ch.vert_x = '0;
		in_ch.vert_y = '0;
		in_ch.vert_z = '0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: every kind on an empty stack, extreme elements pushed
		// onto an empty stack, a product push, and a transform whose w is zero.
		send(KIND_POP, 0, 0, 0, 0, 0, 0, 0);
		send(KIND_XFORM, 0, 0, 0, 0, 32'sd65536, 0, 0);
		send(KIND_READ, 2, 1, 0, 0, 0, 0, 0);
		send(KIND_LOAD, 3, 3, 32'sh7fffffff, 0, 0, 0, 0);
		send(KIND_LOAD, 0, 0, 32'sh80000000, 1, 0, 0, 0);
		send(KIND_READ, 0, 0, 0, 0, 0, 0, 0);
		send(KIND_READ, 3, 3, 0, 0, 0, 0, 0);
		send(KIND_XFORM, 0, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 0);
		send(KIND_XFORM, 0, 0, 0, 0, 32'sh80000000, 32'sh7fffffff, -1);
		// Clearing the w element before the push leaves the product with a
		// bottom row of zeros.
		send(KIND_LOAD, 3, 3, 0, 1, 0, 0, 0);
		send(KIND_XFORM, 0, 0, 0, 0, 32'sd65536, 32'sd65536, 32'sd65536);
		send(KIND_READ, 0, 0, 0, 0, 0, 0, 0);
		send(KIND_POP, 0, 0, 0, 0, 0, 0, 0);
		send(KIND_POP, 0, 0, 0, 0, 0, 0, 0);
		send(KIND_POP, 0, 0, 0, 0, 0, 0, 0);

		// Random part: mostly whole matrices followed by use of the top, with
		// pops, runs of pushes that reach a full stack, and raw noise beats.
		while (sent < ITEMS) begin
			if (sent > ITEMS - 200) calm = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				push_matrix();
			end else if (pick < 55) begin
				send(KIND_XFORM, $urandom, $urandom, $urandom, $urandom,
					coord(), coord(), coord());
			end else if (pick < 68) begin
				send(KIND_READ, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom);
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 3)) send(KIND_POP, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom);
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 20)) send(KIND_LOAD, $urandom, $urandom,
					elem(0, 0, 0), 1, $urandom, $urandom, $urandom);
			end else begin
				send(kind_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom);
			end
		end
		in_ch.valid = 1'b0;

		waited = 0;
		while (pending != 0 && waited < 100000) begin
			@(negedge clk);
			waited++;
		end
		repeat (200) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("transform_matrix_stack_top test passed");
		end else begin
			$display("transform_matrix_stack_top test failed");
		end
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#25ms;
		$display("transform_matrix_stack_top test failed");
		$finish;
	end

endmodule
